// ===== rtl/core/fbvn_pkg.sv =====
package fbvn_pkg;

   // Signed working width of the interpolation datapath.
   typedef logic signed [47:0] cval_type;

   // Control that travels with one octave job through the pipeline.
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [4:0] sh;
   } job_ctl_type;

   typedef enum logic [1:0] {
      REG_SEED_A  = 2'd0,
      REG_SEED_B  = 2'd1,
      REG_OCTAVES = 2'd2
   } reg_idx_type;

   // Fraction numerator width; the fraction is numerator / 125.
   localparam int NUM_W = 23;
   localparam int T_SHIFT = 23;
   localparam logic [16:0] T_RECIP = 17'd67108;
   localparam logic [6:0] DIV_125 = 7'd125;

   localparam int OUT_W = 34;
   localparam cval_type SAT_HI = 48'sh0001_FFFF_FFFF;
   localparam cval_type SAT_LO = 48'shFFFE_0000_0000;

endpackage

// ===== rtl/core/fbvn_cubic.sv =====
module fbvn_cubic
   import fbvn_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  cval_type    p0,
   input  cval_type    p1,
   input  cval_type    p2,
   input  cval_type    p3,
   input  logic [15:0] t,
   output cval_type    result
);

   // Four stages: coefficients, then one Horner step per stage.
   cval_type a_ff, b_ff, c1_ff, c2_ff, p1a_ff, p1b_ff, p1c_ff;
   cval_type acc1_ff, acc2_ff, out_ff;
   logic [15:0] t1_ff, t2_ff, t3_ff;
   cval_type a_in, b_in, acc1_in, acc2_in, out_in;
   logic signed [64:0] m1, m2, m3;

   always_comb begin
      a_in = p3 - p0 + 3 * p1 - 3 * p2;
      b_in = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      m1 = a_ff * $signed({1'b0, t1_ff});
      acc1_in = cval_type'(m1 >>> 16) + b_ff;
      m2 = acc1_ff * $signed({1'b0, t2_ff});
      acc2_in = cval_type'(m2 >>> 16) + c2_ff;
      m3 = acc2_ff * $signed({1'b0, t3_ff});
      out_in = (cval_type'(m3 >>> 16) + p1c_ff) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c1_ff <= p2 - p0;
         p1a_ff <= 2 * p1;
         t1_ff <= t;
         acc1_ff <= acc1_in;
         c2_ff <= c1_ff;
         p1b_ff <= p1a_ff;
         t2_ff <= t1_ff;
         acc2_ff <= acc2_in;
         p1c_ff <= p1b_ff;
         t3_ff <= t2_ff;
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

// ===== rtl/core/fbvn_front.sv =====
module fbvn_front
   import fbvn_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       coord_x,
   input  logic [31:0]       coord_y,
   input  logic [4:0]        levels,
   output job_ctl_type       job_ctl,
   output logic [31:0]       job_qx,
   output logic [NUM_W-1:0]  job_nx,
   output logic [31:0]       job_qy,
   output logic [NUM_W-1:0]  job_ny
);

   localparam int SHIFT_LO = 4 + COORD_FRAC_BITS;
   localparam int MW = 32 - SHIFT_LO;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / 64'd125);
   localparam int DIV = 2000 << COORD_FRAC_BITS;
   localparam int RW = $clog2(DIV);
   localparam logic [RW:0] DIV_W = (RW + 1)'(DIV);

   // Index 0 is x, index 1 is y.
   logic d1_valid_ff, d2_valid_ff, busy_ff;
   logic [MW-1:0] m1_ff [2];
   logic [MW-1:0] e1_ff [2];
   logic [SHIFT_LO-1:0] l1_ff [2];
   logic [31:0] q2_ff [2];
   logic [RW-1:0] r2_ff [2];
   logic [31:0] q_ff [2];
   logic [RW-1:0] r_ff [2];
   logic [4:0] sh_ff, lvl_ff;

   logic [31:0] coord [2];
   logic [2*MW-1:0] prod [2];
   logic [MW-1:0] rem [2];
   logic [MW-1:0] qfix [2];
   logic [MW-1:0] rfix [2];
   logic [32+RW-1:0] dbl_take [2];
   logic [32+RW-1:0] dbl_run [2];
   logic [RW+11:0] sc [2];
   logic is_last, take, d2_free, d1_free;

   function automatic logic [32+RW-1:0] dbl(input logic [31:0] q, input logic [RW-1:0] r);
      logic [RW:0] r2;
      logic [RW:0] rs;
      r2 = {r, 1'b0};
      rs = r2 - DIV_W;
      if (r2 >= DIV_W) begin
         return {q[30:0], 1'b1, rs[RW-1:0]};
      end else begin
         return {q[30:0], 1'b0, r2[RW-1:0]};
      end
   endfunction

   always_comb begin
      coord[0] = coord_x;
      coord[1] = coord_y;
      for (int k = 0; k < 2; k++) begin
         prod[k] = coord[k][31:SHIFT_LO] * RECIP;
         rem[k] = m1_ff[k] - e1_ff[k] * MW'(DIV_125);
         qfix[k] = (rem[k] >= MW'(DIV_125)) ? e1_ff[k] + MW'(1) : e1_ff[k];
         rfix[k] = (rem[k] >= MW'(DIV_125)) ? rem[k] - MW'(DIV_125) : rem[k];
         dbl_take[k] = dbl(q2_ff[k], r2_ff[k]);
         dbl_run[k] = dbl(q_ff[k], r_ff[k]);
         sc[k] = {r_ff[k], 12'b0} >> COORD_FRAC_BITS;
      end
   end

   assign is_last = busy_ff && (sh_ff == lvl_ff);
   assign take = adv && d2_valid_ff && (!busy_ff || is_last);
   assign d2_free = !d2_valid_ff || take;
   assign d1_free = !d1_valid_ff || d2_free;
   assign req_ready = adv && d1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else if (adv) begin
         if (d1_free) begin
            d1_valid_ff <= req_valid;
         end
         if (d2_free) begin
            d2_valid_ff <= d1_valid_ff;
         end
         if (take) begin
            busy_ff <= 1'b1;
         end else if (is_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 2; k++) begin
            if (d1_free) begin
               m1_ff[k] <= coord[k][31:SHIFT_LO];
               l1_ff[k] <= coord[k][SHIFT_LO-1:0];
               e1_ff[k] <= prod[k][2*MW-1:MW];
            end
            if (d2_free) begin
               q2_ff[k] <= 32'(qfix[k]);
               r2_ff[k] <= {rfix[k][6:0], l1_ff[k]};
            end
            if (take) begin
               {q_ff[k], r_ff[k]} <= dbl_take[k];
            end else if (busy_ff && !is_last) begin
               {q_ff[k], r_ff[k]} <= dbl_run[k];
            end
         end
         if (take) begin
            sh_ff <= 5'd1;
            lvl_ff <= levels;
         end else if (busy_ff && !is_last) begin
            sh_ff <= sh_ff + 5'd1;
         end
      end
   end

   always_comb begin
      job_ctl.valid = busy_ff;
      job_ctl.first = (sh_ff == 5'd1);
      job_ctl.last = is_last;
      job_ctl.sh = sh_ff;
      job_qx = q_ff[0];
      job_qy = q_ff[1];
      job_nx = sc[0][NUM_W-1:0];
      job_ny = sc[1][NUM_W-1:0];
   end

   a_sh_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (sh_ff >= 5'd1 && sh_ff <= lvl_ff))
      else $error("octave step outside the active octave range");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, r_ff[0]} < DIV_W && {1'b0, r_ff[1]} < DIV_W))
      else $error("scaled remainder not below the divisor");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(sh_ff) && $stable(busy_ff) && $stable(q_ff[0])))
      else $error("octave issue moved during a stall");

endmodule

// ===== rtl/core/fbvn_octave.sv =====
module fbvn_octave
   import fbvn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  job_ctl_type       ctl_i,
   input  logic [31:0]       qx,
   input  logic [NUM_W-1:0]  nx,
   input  logic [31:0]       qy,
   input  logic [NUM_W-1:0]  ny,
   input  logic [31:0]       seed_a,
   input  logic [31:0]       seed_b,
   input  logic [31:0]       seed_ab,
   output job_ctl_type       ctl_o,
   output cval_type          layer
);

   localparam int STAGES = 11;

   job_ctl_type ctl_ff [STAGES];
   logic [31:0] xs1_ff [4];
   logic [31:0] ys1_ff [4];
   logic [31:0] sqx1_ff [4];
   logic [31:0] sqy1_ff [4];
   logic [NUM_W-1:0] n1_ff [2];
   logic [NUM_W+16:0] p1_ff [2];
   logic [31:0] x2a2_ff [4];
   logic [31:0] y2b2_ff [4];
   logic [31:0] xab2_ff [4];
   logic [31:0] ys2_ff [4];
   logic [15:0] t2_ff [2];
   logic [31:0] h3_ff [16];
   logic [15:0] tx3_ff;
   logic [15:0] ty_ff [5];
   cval_type rows [4];
   cval_type col;

   logic [31:0] xs_in [4];
   logic [31:0] ys_in [4];
   logic [16:0] est [2];
   logic [NUM_W-1:0] rem [2];
   logic [16:0] t_in [2];
   logic [NUM_W-1:0] n_in [2];

   always_comb begin
      n_in[0] = nx;
      n_in[1] = ny;
      for (int j = 0; j < 4; j++) begin
         xs_in[j] = qx - 32'd1 + 32'(j);
         ys_in[j] = qy - 32'd1 + 32'(j);
      end
      for (int k = 0; k < 2; k++) begin
         est[k] = p1_ff[k][NUM_W+16:T_SHIFT];
         rem[k] = n1_ff[k] - NUM_W'(est[k]) * NUM_W'(DIV_125);
         t_in[k] = (rem[k] >= NUM_W'(DIV_125)) ? est[k] + 17'd1 : est[k];
      end
   end

   // Only the valid bits are cleared by reset; the rest of the control follows them.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            ctl_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_i;
         for (int s = 1; s < STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            xs1_ff[j] <= xs_in[j];
            ys1_ff[j] <= ys_in[j];
            sqx1_ff[j] <= xs_in[j] * xs_in[j];
            sqy1_ff[j] <= ys_in[j] * ys_in[j];
            x2a2_ff[j] <= sqx1_ff[j] * seed_a;
            y2b2_ff[j] <= sqy1_ff[j] * seed_b;
            xab2_ff[j] <= xs1_ff[j] * seed_ab;
            ys2_ff[j] <= ys1_ff[j];
         end
         for (int k = 0; k < 2; k++) begin
            n1_ff[k] <= n_in[k];
            p1_ff[k] <= n_in[k] * T_RECIP;
            t2_ff[k] <= t_in[k][15:0];
         end
         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
               h3_ff[4*k+j] <= x2a2_ff[j] + y2b2_ff[k] + xab2_ff[j] * ys2_ff[k];
            end
         end
         tx3_ff <= t2_ff[0];
         ty_ff[0] <= t2_ff[1];
         for (int s = 1; s < 5; s++) begin
            ty_ff[s] <= ty_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_row
      fbvn_cubic u_row (
         .clock  (clock),
         .en     (en),
         .p0     (cval_type'({16'b0, h3_ff[4*k]})),
         .p1     (cval_type'({16'b0, h3_ff[4*k+1]})),
         .p2     (cval_type'({16'b0, h3_ff[4*k+2]})),
         .p3     (cval_type'({16'b0, h3_ff[4*k+3]})),
         .t      (tx3_ff),
         .result (rows[k])
      );
   end

   fbvn_cubic u_col (
      .clock  (clock),
      .en     (en),
      .p0     (rows[0]),
      .p1     (rows[1]),
      .p2     (rows[2]),
      .p3     (rows[3]),
      .t      (ty_ff[4]),
      .result (col)
   );

   assign ctl_o = ctl_ff[STAGES-1];
   assign layer = col;

endmodule

// ===== rtl/core/fractal_bicubic_value_noise.sv =====
// Fractal bicubic value noise generator.
// Request channel (req_valid/req_ready): one coordinate pair per item, both
// coordinates unsigned Q24.8. Response channel (rsp_valid/rsp_ready): one
// signed noise value per item, scaled by 2^32, in request order.
// Configuration is an APB-style port (psel, penable, pwrite, paddr, pwdata,
// prdata, pready) with seed_a at 0x0, seed_b at 0x4 and octave_count at 0x8.
// Registers must only be written while no item is in flight.
// Each item is expanded into L octave jobs, L being the clamped octave count,
// which enter a shared octave pipeline at one job per cycle unless the
// receiver stalls. The first job of a waiting item follows the last job of
// the one before directly, so the single octave unit sets the item rate.
// The result passes through three front stages (reciprocal divide,
// correction, octave issue), eleven octave stages (hash and two Catmull-Rom
// passes), then the accumulate stage that drives rsp.
// Reset restores the register defaults and empties the pipeline.
// When the receiver stalls, the whole pipeline freezes in place; nothing is
// dropped or repeated, and req_ready stays low until the waiting result is
// taken.
module fractal_bicubic_value_noise
   import fbvn_pkg::*;
#(
   parameter int MAX_OCTAVES = 16,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_coord_x,
   input  logic [31:0]             req_coord_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_noise_value,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [31:0] seed_a_ff, seed_b_ff, seed_ab_ff;
   logic [4:0] octaves_ff;
   logic rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_noise_ff;
   cval_type acc_ff;

   logic adv;
   logic [4:0] levels;
   reg_idx_type idx;
   job_ctl_type job_ctl, oct_ctl;
   logic [31:0] job_qx, job_qy;
   logic [NUM_W-1:0] job_nx, job_ny;
   cval_type layer, weighted, sum_in;

   // The pipeline moves whenever the output register is free or being read.
   assign adv = !rsp_valid_ff || rsp_ready;
   assign idx = reg_idx_type'(paddr[3:2]);
   assign pready = 1'b1;

   always_comb begin
      case (idx)
         REG_SEED_A:  prdata = seed_a_ff;
         REG_SEED_B:  prdata = seed_b_ff;
         REG_OCTAVES: prdata = {27'b0, octaves_ff};
         default:     prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff <= 32'd1;
         seed_b_ff <= 32'd1;
         octaves_ff <= 5'd8;
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_SEED_A:  seed_a_ff <= pwdata;
            REG_SEED_B:  seed_b_ff <= pwdata;
            REG_OCTAVES: octaves_ff <= pwdata[4:0];
            default:     ;
         endcase
      end
   end

   // The cross term of the hash uses the product of both seeds.
   always_ff @(posedge clock) begin
      seed_ab_ff <= seed_a_ff * seed_b_ff;
   end

   // A count of zero behaves as one octave; large counts stop at the maximum.
   always_comb begin
      if (octaves_ff == 5'd0) begin
         levels = 5'd1;
      end else if (octaves_ff > 5'(MAX_OCTAVES)) begin
         levels = 5'(MAX_OCTAVES);
      end else begin
         levels = octaves_ff;
      end
   end

   fbvn_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .levels    (levels),
      .job_ctl   (job_ctl),
      .job_qx    (job_qx),
      .job_nx    (job_nx),
      .job_qy    (job_qy),
      .job_ny    (job_ny)
   );

   fbvn_octave u_octave (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .ctl_i   (job_ctl),
      .qx      (job_qx),
      .nx      (job_nx),
      .qy      (job_qy),
      .ny      (job_ny),
      .seed_a  (seed_a_ff),
      .seed_b  (seed_b_ff),
      .seed_ab (seed_ab_ff),
      .ctl_o   (oct_ctl),
      .layer   (layer)
   );

   // Each octave is weighted by a floor shift and added to the running sum;
   // the first octave of an item restarts the sum.
   always_comb begin
      weighted = layer >>> oct_ctl.sh;
      sum_in = (oct_ctl.first ? cval_type'(0) : acc_ff) + weighted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= oct_ctl.valid && oct_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && oct_ctl.valid) begin
         acc_ff <= sum_in;
         if (oct_ctl.last) begin
            if (sum_in > SAT_HI) begin
               rsp_noise_ff <= SAT_HI[OUT_W-1:0];
            end else if (sum_in < SAT_LO) begin
               rsp_noise_ff <= SAT_LO[OUT_W-1:0];
            end else begin
               rsp_noise_ff <= sum_in[OUT_W-1:0];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   a_result_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (adv && !(oct_ctl.valid && oct_ctl.last)) |=> !rsp_valid)
      else $error("result raised without a final octave");

   a_first_before_last: assert property (@(posedge clock) disable iff (reset)
      (oct_ctl.valid && oct_ctl.first && oct_ctl.sh != 5'd1) |-> 1'b0)
      else $error("octave sum restarted on a later octave");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(acc_ff))
      else $error("accumulator moved while the output was stalled");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fbvn_pkg::*;

   // Noise scoreboard: keeps its own copy of the registers and predicts the
   // summed fractal noise for every accepted coordinate pair.
   class noise_scoreboard;
      bit [31:0] seed_a;
      bit [31:0] seed_b;
      bit [4:0] octaves;
      bit signed [33:0] pending_noise[$];
      int errors;

      function new();
         seed_a = 1;
         seed_b = 1;
         octaves = 8;
         errors = 0;
      endfunction

      function void set_reg(reg_idx_type idx, bit [31:0] v);
         case (idx)
            REG_SEED_A: seed_a = v;
            REG_SEED_B: seed_b = v;
            REG_OCTAVES: octaves = v[4:0];
            default: ;
         endcase
      endfunction

      function longint hash_point(bit [31:0] x, bit [31:0] y);
         bit [31:0] h;
         h = x * x * seed_a + y * y * seed_b + x * y * (seed_a * seed_b);
         return longint'({32'd0, h});
      endfunction

      function longint catmull(longint t, longint p0, longint p1, longint p2, longint p3);
         longint a, b, c, acc;
         a = -p0 + 3 * p1 - 3 * p2 + p3;
         b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         c = p2 - p0;
         acc = ((a * t) >>> 16) + b;
         acc = ((acc * t) >>> 16) + c;
         acc = ((acc * t) >>> 16) + 2 * p1;
         return acc >>> 1;
      endfunction

      function void split_axis(bit [31:0] coord, int sh, output bit [31:0] idx,
                               output longint frac);
         bit [63:0] n, d;
         n = {32'd0, coord} << sh;
         d = 64'd2000 << 8;
         idx = 32'((n / d) & 64'hFFFF_FFFF);
         frac = longint'(((n % d) << 16) / d);
      endfunction

      function longint octave_layer(bit [31:0] cx, bit [31:0] cy, int sh);
         bit [31:0] ix, iy;
         longint fx, fy;
         longint row[4];
         split_axis(cx, sh, ix, fx);
         split_axis(cy, sh, iy, fy);
         ix = ix - 1;
         iy = iy - 1;
         for (int k = 0; k < 4; k++) begin
            row[k] = catmull(fx, hash_point(ix, iy + k), hash_point(ix + 1, iy + k),
                             hash_point(ix + 2, iy + k), hash_point(ix + 3, iy + k));
         end
         return catmull(fy, row[0], row[1], row[2], row[3]);
      endfunction

      function void note_request(bit [31:0] cx, bit [31:0] cy);
         int lv;
         longint total;
         lv = octaves;
         if (lv < 1) lv = 1;
         if (lv > 16) lv = 16;
         total = 0;
         for (int i = 0; i < lv; i++) begin
            total += octave_layer(cx, cy, lv - i) >>> (lv - i);
         end
         if (total > 64'sh1_FFFF_FFFF) total = 64'sh1_FFFF_FFFF;
         if (total < -64'sh2_0000_0000) total = -64'sh2_0000_0000;
         pending_noise.push_back(34'(total));
      endfunction

      function void check_result(bit signed [33:0] got);
         bit signed [33:0] want;
         if (pending_noise.size() == 0) begin
            $error("noise_value: result with no expectation, actual %0d", got);
            errors++;
            return;
         end
         want = pending_noise.pop_front();
         if (want !== got) begin
            $error("noise_value mismatch: expected %0d actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [31:0] req_coord_x = 0;
   logic [31:0] req_coord_y = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [OUT_W-1:0] rsp_noise_value;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [3:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   noise_scoreboard board = new();
   // Idle odds in percent for the two sides; changed phase by phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int accepted_items = 0;
   int idle_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   always #4 clock = ~clock;

   fractal_bicubic_value_noise dut (.*);

   // The receiver stalls at random; each accepted result is checked at the
   // edge where it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_noise_value);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: counts cycles where neither channel moves an item while work is outstanding.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset ||
          (board.pending_noise.size() == 0 && !req_valid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Writes one register through the setup and access cycles, then returns
   // the bus to idle; the block is idle whenever this runs.
   task automatic write_reg(reg_idx_type idx, bit [31:0] v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= 4'(idx) << 2;
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, v);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   // Offers one coordinate pair, with a random idle gap first, and holds it
   // until the block takes it. The prediction is made at acceptance. Valid
   // is left high on return; the next call or the drain decides its value.
   task automatic send_item(bit [31:0] cx, bit [31:0] cy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_coord_x <= cx;
      req_coord_y <= cy;
      do @(posedge clock); while (!req_ready);
      board.note_request(cx, cy);
      accepted_items++;
   endtask

   // Stops offering items, waits for every expected result, then lets the
   // pipeline drain fully.
   task automatic drain();
      req_valid <= 0;
      while (board.pending_noise.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Mostly small coordinates so that low octaves see nearby lattice cells,
   // with some full-range values to reach large lattice indices.
   function automatic bit [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(4096);
         default: return $urandom_range(1 << 20);
      endcase
   endfunction

   task automatic random_phase(int count, int sidle, int ridle);
      send_idle_pct = sidle;
      recv_stall_pct = ridle;
      for (int i = 0; i < count; i++) send_item(random_coord(), random_coord());
      send_idle_pct = 0;
      drain();
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at reset settings: coordinate extremes, including
      // values whose lattice index wraps around 2^32.
      send_item(0, 0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 0);
      send_item(0, 32'hFFFF_FFFF);
      send_item(32'h5555_5555, 32'hAAAA_AAAA);
      send_item(32'd512000, 32'd511999);
      drain();
      // Octave count extremes, including zero (treated as one) and values
      // above the maximum (treated as the maximum).
      write_reg(REG_SEED_A, 32'hFFFF_FFFF);
      write_reg(REG_SEED_B, 32'hFFFF_FFFF);
      write_reg(REG_OCTAVES, 0);
      send_item(32'h1234_5678, 32'h8765_4321);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_reg(REG_OCTAVES, 31);
      send_item(32'hFFFF_FFFF, 0);
      send_item(32'h0000_0100, 32'h0000_0100);
      drain();
      write_reg(REG_SEED_A, 0);
      write_reg(REG_SEED_B, 0);
      write_reg(REG_OCTAVES, 16);
      send_item(32'hDEAD_BEEF, 32'hCAFE_F00D);
      drain();

      // Random phases walk through register settings and idle patterns.
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(REG_SEED_A, (ph % 4 == 0) ? 32'hFFFF_FFFF : $urandom());
         write_reg(REG_SEED_B, (ph % 4 == 1) ? 32'd0 : $urandom());
         write_reg(REG_OCTAVES, (ph % 3 == 0) ? 5'($urandom_range(1, 3)) :
                                (ph % 3 == 1) ? 5'd16 : 5'($urandom_range(31)));
         case (ph % 4)
            0: random_phase(153, 0, 0);
            1: random_phase(153, 85, 0);
            2: random_phase(153, 0, 85);
            default: random_phase(153, 24, 24);
         endcase
      end

      $display("Covered %0d coordinate pairs over seed and octave settings,",
               accepted_items);
      $display("including extreme coordinates and idle/stall patterns.");
      if (board.errors == 0 && board.pending_noise.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/fbvn_pkg.sv
rtl/core/fbvn_cubic.sv
rtl/core/fbvn_front.sv
rtl/core/fbvn_octave.sv
rtl/core/fractal_bicubic_value_noise.sv
dv/tb_top.sv
